// ===== rtl/ttba_pkg.sv =====
// Shared types and constants for the tag bitmap allocator.
package ttba_pkg;

    // Width of a tag number on the ports
    localparam int TAG_W = 8;

    // Largest tag number that the ports can carry
    localparam int TAG_MAX = (1 << TAG_W) - 1;

    // Default geometry of the used-map
    localparam int DEF_MAP_WORDS = 4;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FIRST_TAG = 1;

    // Command codes
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } ttba_cmd_t;

    // Search result handed from the zero finder to the top level
    typedef struct packed {
        logic             found;
        logic [TAG_W-1:0] pos;
    } ttba_hit_t;

endpackage

// ===== rtl/ttba_find_zero.sv =====
// Lowest-clear-bit search over the used-map: word level first, then bit level.
module ttba_find_zero #(
    parameter int MAP_WORDS = ttba_pkg::DEF_MAP_WORDS,
    parameter int WORD_BITS = ttba_pkg::DEF_WORD_BITS,
    parameter int FIRST_TAG = ttba_pkg::DEF_FIRST_TAG
) (
    input  logic [MAP_WORDS*WORD_BITS-1:0] map,
    output ttba_pkg::ttba_hit_t            hit
);
    import ttba_pkg::*;

    localparam int TOTAL  = MAP_WORDS * WORD_BITS;
    localparam int LIMIT  = TAG_MAX + 1 - FIRST_TAG;
    // Positions whose tag would not fit on the ports do not exist
    localparam int USABLE = (TOTAL < LIMIT) ? TOTAL : LIMIT;
    localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [TOTAL-1:0]     avail;
    logic [MAP_WORDS-1:0] word_free;
    logic [WIDX_W-1:0]    word_sel;
    logic [WORD_BITS-1:0] avail_word;
    logic [BIT_W-1:0]     bit_sel;
    logic                 found;

    // Free and existing positions, and which words hold at least one
    always_comb
    begin
        for (int i = 0; i < TOTAL; i++)
        begin
            avail[i] = !map[i] && (i < USABLE);
        end
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            word_free[w] = |avail[w*WORD_BITS +: WORD_BITS];
        end
    end

    // Lowest word with a free position
    always_comb
    begin
        found    = 1'b0;
        word_sel = '0;
        for (int w = MAP_WORDS - 1; w >= 0; w--)
        begin
            if (word_free[w])
            begin
                found    = 1'b1;
                word_sel = WIDX_W'(w);
            end
        end
    end

    // Lowest free bit within that word
    always_comb
    begin
        avail_word = avail[word_sel*WORD_BITS +: WORD_BITS];
        bit_sel    = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail_word[b])
            begin
                bit_sel = BIT_W'(b);
            end
        end
    end

    assign hit.found = found;
    assign hit.pos   = TAG_W'(int'(word_sel) * WORD_BITS + int'(bit_sel));

endmodule

// ===== rtl/touch_tag_bitmap_allocator.sv =====
// Top level of the tag bitmap allocator: command register, used-map and result register.
//
// Hands out tag numbers FIRST_TAG upward from a used-map of MAP_WORDS x WORD_BITS
// bits, all free after reset. A command beat is taken whenever start is high and
// busy is low; busy is high only in the first cycle after reset, so one command
// can be given every cycle. Each command produces exactly one result beat, through
// the command and result registers, marked by done for one cycle; the receiver must
// take it then. An allocate returns the lowest free tag, or 0 with none_free set
// when no tag is free (tags above 255 count as non-existent). A free clears the
// given tag's bit and returns 0; tags outside the map are ignored. The map lookup
// and update for one command complete combinationally between the command register
// and the result register, so consecutive commands always see each other's effect.
module touch_tag_bitmap_allocator #(
    parameter int MAP_WORDS = ttba_pkg::DEF_MAP_WORDS,
    parameter int WORD_BITS = ttba_pkg::DEF_WORD_BITS,
    parameter int FIRST_TAG = ttba_pkg::DEF_FIRST_TAG
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       command,
    input  logic [ttba_pkg::TAG_W-1:0] free_tag,
    output logic                       done,
    output logic [ttba_pkg::TAG_W-1:0] granted_tag,
    output logic                       none_free
);
    import ttba_pkg::*;

    localparam int TOTAL = MAP_WORDS * WORD_BITS;
    localparam int POS_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    // Command stage
    logic              busy_reg;
    logic              cmd_vld_reg;
    ttba_cmd_t         cmd_reg;
    logic [TAG_W-1:0]  tag_reg;

    // Map and result stage
    logic [TOTAL-1:0]  used_map_reg;
    logic [TOTAL-1:0]  used_map_next;
    logic              done_reg;
    logic [TAG_W-1:0]  granted_tag_reg;
    logic [TAG_W-1:0]  granted_tag_next;
    logic              none_free_reg;
    logic              none_free_next;

    ttba_hit_t         hit;
    logic [TAG_W:0]    free_idx;
    logic              free_in_map;
    logic              accept;

    assign accept = start && !busy_reg;

    // Command register: one beat per cycle while busy is low
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            cmd_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= 1'b0;
            cmd_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= ttba_cmd_t'(command);
            tag_reg <= free_tag;
        end
    end

    // Lowest free position
    ttba_find_zero #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS),
        .FIRST_TAG (FIRST_TAG)
    ) u_find (
        .map (used_map_reg),
        .hit (hit)
    );

    // Map position of a tag being freed
    assign free_idx    = {1'b0, tag_reg} - (TAG_W+1)'(FIRST_TAG);
    assign free_in_map = (tag_reg >= TAG_W'(FIRST_TAG)) && (free_idx < (TAG_W+1)'(TOTAL));

    // Map update and result
    always_comb
    begin
        used_map_next    = used_map_reg;
        granted_tag_next = '0;
        none_free_next   = 1'b0;
        if (cmd_vld_reg)
        begin
            case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (hit.found)
                    begin
                        used_map_next[hit.pos[POS_W-1:0]] = 1'b1;
                        granted_tag_next = hit.pos + TAG_W'(FIRST_TAG);
                    end
                    else
                    begin
                        none_free_next = 1'b1;
                    end
                end
                CMD_FREE:
                begin
                    if (free_in_map)
                    begin
                        used_map_next[free_idx[POS_W-1:0]] = 1'b0;
                    end
                end
                default:
                begin
                    used_map_next = used_map_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_map_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            used_map_reg <= used_map_next;
            done_reg     <= cmd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_vld_reg)
        begin
            granted_tag_reg <= granted_tag_next;
            none_free_reg   <= none_free_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign granted_tag = granted_tag_reg;
    assign none_free   = none_free_reg;

    // Map position of the tag just granted
    logic [TAG_W-1:0] grant_pos;
    assign grant_pos = granted_tag_reg - TAG_W'(FIRST_TAG);

    // A result beat always follows an accepted command through the command and result registers
    a_done_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept, 2) && !$past(busy_reg, 2) |-> done_reg)
        else $error("result beat missing for an accepted command");

    // No tag is returned together with the none-free flag
    a_none_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && none_free_reg |-> granted_tag_reg == '0)
        else $error("tag returned while flagging none free");

    // A granted tag is marked used in the map while its beat is shown
    a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && granted_tag_reg != '0 |-> used_map_reg[grant_pos[POS_W-1:0]])
        else $error("granted tag not marked in use");

    // An allocate that sees no free position is reported with none_free and done
    a_fail_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_vld_reg && cmd_reg == CMD_ALLOC && !hit.found |=> none_free_reg && done_reg)
        else $error("failed allocate not reported");

endmodule
